[sv/dnstxt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnstxt_pkg
// Types and constants shared by the DNS TXT answer parser.
// ----------------------------------------------------------------------------
package dnstxt_pkg;

  localparam int unsigned HDR_BYTES       = 12;
  localparam int unsigned QFIXEDSZ        = 4;
  localparam int unsigned ANS_FIXED_BYTES = 10;
  localparam logic [15:0] T_TXT           = 16'd16;
  localparam int unsigned RES_PER_BYTE    = 3;
  localparam int unsigned OUTQ_DEPTH      = 4;

  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_END    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NO_TXT    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QN_START,
    PH_QN_LABEL,
    PH_QN_PTR,
    PH_QN_FIXED,
    PH_AN_START,
    PH_AN_LABEL,
    PH_AN_PTR,
    PH_AN_FIXED,
    PH_SKIP,
    PH_TLEN,
    PH_TTEXT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [7:0]  text_byte;
    logic [15:0] record_number;
    status_t     parse_status;
  } out_item_t;

  // results of one byte, in output order: text, end mark, status
  typedef struct packed {
    logic [RES_PER_BYTE-1:0]            vld;
    out_item_t [RES_PER_BYTE-1:0]       item;
  } push_t;

endpackage

`default_nettype wire

[sv/dnstxt_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnstxt_parser
// Per-byte message state: header, question/answer names, fixed fields and
// TXT rdata. Produces up to three results for each transferred byte.
// ----------------------------------------------------------------------------
module dnstxt_parser
  import dnstxt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_item_t in_data,
  output push_t         push
);

  phase_t      phase_r, phase_nxt, phase_adv;
  logic [3:0]  fc_r, fc_nxt, fc_adv;
  logic [15:0] qleft_r, qleft_nxt, qleft_adv;
  logic [15:0] aleft_r, aleft_nxt, aleft_adv;
  logic [15:0] atype_r, atype_nxt, atype_adv;
  logic [15:0] rdata_r, rdata_nxt, rdata_adv;
  logic [7:0]  sleft_r, sleft_nxt, sleft_adv;
  logic [5:0]  lleft_r, lleft_nxt, lleft_adv;
  logic [15:0] found_r, found_nxt, found_adv;
  logic        err_r, err_nxt, err_adv;

  logic [7:0]  b;
  logic [15:0] rd_dec;
  logic [15:0] ans_dec;
  logic [15:0] q_dec;
  logic [15:0] rdata_full;
  logic [7:0]  s_dec;
  logic [5:0]  l_dec;
  logic        is_a;
  phase_t      after_answer;
  logic        active;

  logic        text_v, end_v;
  logic [15:0] end_rec;
  status_t     status;

  assign b          = in_data.msg_byte;
  assign rd_dec     = rdata_r - 16'd1;
  assign ans_dec    = aleft_r - 16'd1;
  assign q_dec      = qleft_r - 16'd1;
  assign rdata_full = rdata_r | {8'd0, b};
  assign s_dec      = sleft_r - 8'd1;
  assign l_dec      = lleft_r - 6'd1;
  assign is_a       = (phase_r == PH_AN_START) || (phase_r == PH_AN_LABEL) ||
                      (phase_r == PH_AN_PTR);
  assign after_answer = (ans_dec != 16'd0) ? PH_AN_START : PH_DONE;
  assign active     = !err_r && (phase_r != PH_DONE);

  // next state
  always_comb begin
    phase_adv = phase_r;
    fc_adv    = fc_r;
    qleft_adv = qleft_r;
    aleft_adv = aleft_r;
    atype_adv = atype_r;
    rdata_adv = rdata_r;
    sleft_adv = sleft_r;
    lleft_adv = lleft_r;
    found_adv = found_r;
    err_adv   = err_r;
    if (active) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (fc_r == 4'd4) qleft_adv = {b, 8'd0};
          if (fc_r == 4'd5) qleft_adv = qleft_r | {8'd0, b};
          if (fc_r == 4'd6) aleft_adv = {b, 8'd0};
          if (fc_r == 4'd7) aleft_adv = aleft_r | {8'd0, b};
          if (fc_r >= 4'(HDR_BYTES - 1)) begin
            if (qleft_r != 16'd0)      phase_adv = PH_QN_START;
            else if (aleft_r != 16'd0) phase_adv = PH_AN_START;
            else                       phase_adv = PH_DONE;
          end else begin
            fc_adv = fc_r + 4'd1;
          end
        end
        PH_QN_START, PH_AN_START: begin
          if (b == 8'd0) begin
            phase_adv = is_a ? PH_AN_FIXED : PH_QN_FIXED;
            fc_adv    = 4'd0;
          end else if (b[7:6] == 2'b00) begin
            lleft_adv = b[5:0];
            phase_adv = is_a ? PH_AN_LABEL : PH_QN_LABEL;
          end else if (b[7:6] == 2'b11) begin
            phase_adv = is_a ? PH_AN_PTR : PH_QN_PTR;
          end else begin
            err_adv = 1'b1;
          end
        end
        PH_QN_LABEL, PH_AN_LABEL: begin
          lleft_adv = l_dec;
          if (l_dec == 6'd0) phase_adv = is_a ? PH_AN_START : PH_QN_START;
        end
        PH_QN_PTR, PH_AN_PTR: begin
          phase_adv = is_a ? PH_AN_FIXED : PH_QN_FIXED;
          fc_adv    = 4'd0;
        end
        PH_QN_FIXED: begin
          if (fc_r >= 4'(QFIXEDSZ - 1)) begin
            qleft_adv = q_dec;
            if (q_dec != 16'd0)        phase_adv = PH_QN_START;
            else if (aleft_r != 16'd0) phase_adv = PH_AN_START;
            else                       phase_adv = PH_DONE;
          end else begin
            fc_adv = fc_r + 4'd1;
          end
        end
        PH_AN_FIXED: begin
          if (fc_r == 4'd0) atype_adv = {b, 8'd0};
          if (fc_r == 4'd1) atype_adv = atype_r | {8'd0, b};
          if (fc_r == 4'd8) rdata_adv = {b, 8'd0};
          if (fc_r == 4'd9) rdata_adv = rdata_full;
          if (fc_r >= 4'(ANS_FIXED_BYTES - 1)) begin
            if (fc_r == 4'd9) begin
              if (atype_r == T_TXT) begin
                found_adv = found_r + 16'd1;
                if (rdata_full == 16'd0) begin
                  aleft_adv = ans_dec;
                  phase_adv = after_answer;
                end else begin
                  phase_adv = PH_TLEN;
                end
              end else if (rdata_full == 16'd0) begin
                aleft_adv = ans_dec;
                phase_adv = after_answer;
              end else begin
                phase_adv = PH_SKIP;
              end
            end else begin
              if (atype_r == T_TXT) begin
                found_adv = found_r + 16'd1;
                if (rdata_r == 16'd0) begin
                  aleft_adv = ans_dec;
                  phase_adv = after_answer;
                end else begin
                  phase_adv = PH_TLEN;
                end
              end else if (rdata_r == 16'd0) begin
                aleft_adv = ans_dec;
                phase_adv = after_answer;
              end else begin
                phase_adv = PH_SKIP;
              end
            end
          end else begin
            fc_adv = fc_r + 4'd1;
          end
        end
        PH_SKIP: begin
          rdata_adv = rd_dec;
          if (rd_dec == 16'd0) begin
            aleft_adv = ans_dec;
            phase_adv = after_answer;
          end
        end
        PH_TLEN: begin
          rdata_adv = rd_dec;
          if ({8'd0, b} > rd_dec) begin
            err_adv = 1'b1;
          end else if (b == 8'd0) begin
            if (rd_dec == 16'd0) begin
              aleft_adv = ans_dec;
              phase_adv = after_answer;
            end
          end else begin
            sleft_adv = b;
            phase_adv = PH_TTEXT;
          end
        end
        PH_TTEXT: begin
          rdata_adv = rd_dec;
          sleft_adv = s_dec;
          if (s_dec == 8'd0) begin
            if (rd_dec == 16'd0) begin
              aleft_adv = ans_dec;
              phase_adv = after_answer;
            end else begin
              phase_adv = PH_TLEN;
            end
          end
        end
        default: begin
          err_adv = 1'b1;
        end
      endcase
    end

    if (in_data.msg_last) begin
      phase_nxt = PH_HEADER;
      fc_nxt    = 4'd0;
      qleft_nxt = 16'd0;
      aleft_nxt = 16'd0;
      atype_nxt = 16'd0;
      rdata_nxt = 16'd0;
      sleft_nxt = 8'd0;
      lleft_nxt = 6'd0;
      found_nxt = 16'd0;
      err_nxt   = 1'b0;
    end else begin
      phase_nxt = phase_adv;
      fc_nxt    = fc_adv;
      qleft_nxt = qleft_adv;
      aleft_nxt = aleft_adv;
      atype_nxt = atype_adv;
      rdata_nxt = rdata_adv;
      sleft_nxt = sleft_adv;
      lleft_nxt = lleft_adv;
      found_nxt = found_adv;
      err_nxt   = err_adv;
    end
  end

  // results
  always_comb begin
    text_v  = 1'b0;
    end_v   = 1'b0;
    end_rec = found_r - 16'd1;
    if (active) begin
      unique case (phase_r)
        PH_AN_FIXED: begin
          if (fc_r == 4'd9 && atype_r == T_TXT && rdata_full == 16'd0) begin
            end_v   = 1'b1;
            end_rec = found_r;
          end else if (fc_r > 4'd9 && atype_r == T_TXT && rdata_r == 16'd0) begin
            end_v   = 1'b1;
            end_rec = found_r;
          end
        end
        PH_TLEN: begin
          end_v = (b == 8'd0) && (rd_dec == 16'd0);
        end
        PH_TTEXT: begin
          text_v = 1'b1;
          end_v  = (s_dec == 8'd0) && (rd_dec == 16'd0);
        end
        default: begin
          end_v = 1'b0;
        end
      endcase
    end

    if (err_adv || phase_adv != PH_DONE) status = ST_MALFORMED;
    else if (found_adv == 16'd0)         status = ST_NO_TXT;
    else                                 status = ST_OK;

    push.vld[0]                = text_v;
    push.item[0].out_kind      = KIND_TEXT;
    push.item[0].text_byte     = b;
    push.item[0].record_number = found_r - 16'd1;
    push.item[0].parse_status  = ST_OK;

    push.vld[1]                = end_v;
    push.item[1].out_kind      = KIND_END;
    push.item[1].text_byte     = 8'd0;
    push.item[1].record_number = end_rec;
    push.item[1].parse_status  = ST_OK;

    push.vld[2]                = in_data.msg_last;
    push.item[2].out_kind      = KIND_STATUS;
    push.item[2].text_byte     = 8'd0;
    push.item[2].record_number = found_adv;
    push.item[2].parse_status  = status;

    if (!step) push.vld = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      fc_r    <= 4'd0;
      qleft_r <= 16'd0;
      aleft_r <= 16'd0;
      atype_r <= 16'd0;
      rdata_r <= 16'd0;
      sleft_r <= 8'd0;
      lleft_r <= 6'd0;
      found_r <= 16'd0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      qleft_r <= qleft_nxt;
      aleft_r <= aleft_nxt;
      atype_r <= atype_nxt;
      rdata_r <= rdata_nxt;
      sleft_r <= sleft_nxt;
      lleft_r <= lleft_nxt;
      found_r <= found_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/dnstxt_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnstxt_outq
// Small result queue: takes up to three results per cycle, delivers one per
// out_ready cycle; ready for a new byte while room for a full burst remains.
// ----------------------------------------------------------------------------
module dnstxt_outq
  import dnstxt_pkg::*;
#(
  parameter int unsigned DEPTH = OUTQ_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  out_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [DEPTH-1:0] we;
  out_item_t       wdata [DEPTH];
  logic [CW-1:0]   npush;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  assign room      = (cnt_r <= CW'(DEPTH - RES_PER_BYTE));

  always_comb begin
    logic [PW-1:0] p;
    p     = wp_r;
    npush = '0;
    we    = '0;
    for (int k = 0; k < DEPTH; k++) wdata[k] = mem_r[k];
    for (int i = 0; i < RES_PER_BYTE; i++) begin
      if (push.vld[i]) begin
        we[p]    = 1'b1;
        wdata[p] = push.item[i];
        p        = ptr_inc(p);
        npush    = npush + CW'(1);
      end
    end
    wp_nxt  = p;
    rp_nxt  = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + npush - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (we[k]) mem_r[k] <= wdata[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/dns_txt_answer_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_txt_answer_parser
// Walks a DNS response byte by byte and emits TXT text bytes, end-of-record
// marks and a final status per message.
//
//   channel | dir | payload     | transfer when
//   in_     | in  | in_item_t   | in_valid  && in_ready
//   out_    | out | out_item_t  | out_valid && out_ready
//
// One byte per cycle while in_ready is high; each byte makes 0 to 3 results,
// queued in dnstxt_outq. in_ready is high while the queue holds at most
// DEPTH-3 entries, so a byte with two or three results can hold it low until
// the queue drains to that level; one result is delivered per out_ready cycle.
// Synchronous reset returns the parser to header phase and empties the queue.
// ----------------------------------------------------------------------------
module dns_txt_answer_parser
  import dnstxt_pkg::*;
#(
  parameter int unsigned OUTQ_DEPTH_P = OUTQ_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  push_t push;
  logic  step;

  assign step = in_valid && in_ready;

  dnstxt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_data (in_data),
    .push    (push)
  );

  dnstxt_outq #(
    .DEPTH (OUTQ_DEPTH_P)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
